>>> hdl/tspl_pkg.sv
package tspl_pkg;

    // Pool geometry.
    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EXC_W = CNT_W + 1;

    // Field widths.
    localparam int TIME_W   = 16;
    localparam int SIU_W    = 5;
    localparam int LIMIT_W  = 7;
    localparam int OUT_IDX_W = 4;
    localparam int OUT_CNT_W = 5;

    // Register reset values.
    localparam logic [SIU_W-1:0]   SIU_RESET   = 5'd16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd10;
    localparam logic [TIME_W-1:0]  FADE_RESET  = 16'd800;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [1:0] REG_LINGER_LIMIT = 2'd1;
    localparam logic [1:0] REG_FADE_MS      = 2'd2;

    // Operation codes.
    localparam logic [1:0] OP_SPAWN   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Slot phases.
    typedef logic [1:0] phase_t;
    localparam phase_t PH_FREE   = 2'd0;
    localparam phase_t PH_ACTIVE = 2'd1;
    localparam phase_t PH_LINGER = 2'd2;
    localparam phase_t PH_FADE   = 2'd3;

endpackage

>>> hdl/timed_slot_pool_lifecycle_unit.sv
// Spawn: one slot probed a cycle until a free slot is found or the spawn limit is reached.
// Tick: an update pass over every slot, then an evict pass when the live count reaches
// the linger limit, then the result; one shared saturating subtractor walks the slots.
// Clear: one slot freed a cycle. Unknown opcode: straight to the result.
// One transaction at a time; s_tready is high only while the sequencer is idle.
// Synchronous active-low reset frees every slot, loads register defaults, empties output.
module timed_slot_pool_lifecycle_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] lifetime_ms, [16] free_on_timeout, [32:17] elapsed_ms, [39:33] zero
    input  logic [39:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] slot_index, [4] spawn_ok, [9:5] live_count, [14:10] evicted_count, [15] zero
    output logic [15:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPAWN = 3'd1;
    localparam logic [2:0] ST_TICK  = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int CW = tspl_pkg::CNT_W;
    localparam int EW = tspl_pkg::EXC_W;
    localparam int TW = tspl_pkg::TIME_W;

    // Configuration registers.
    logic [tspl_pkg::SIU_W-1:0]   cfg_siu_reg;
    logic [tspl_pkg::LIMIT_W-1:0] cfg_limit_reg;
    logic [TW-1:0]                cfg_fade_reg;

    // Slot state.
    tspl_pkg::phase_t phase_reg [tspl_pkg::SLOTS];
    logic [TW-1:0]    timer_reg [tspl_pkg::SLOTS];
    logic             lingers_reg [tspl_pkg::SLOTS];

    // Sequencer and result registers.
    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] live_reg, live_next;
    logic [EW-1:0] excess_reg, excess_next;
    logic [CW-1:0] evict_reg, evict_next;
    logic [tspl_pkg::OUT_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic        res_ok_reg, res_ok_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    // Captured transaction payload.
    logic [1:0]    op_reg;
    logic [TW-1:0] life_reg;
    logic          fot_reg;
    logic [TW-1:0] dt_reg;

    // Slot write port.
    logic             ph_we, tm_we, lg_we;
    tspl_pkg::phase_t ph_wdata;
    logic [TW-1:0]    tm_wdata;
    logic             lg_wdata;

    logic [tspl_pkg::IDX_W-1:0] slot;
    tspl_pkg::phase_t ph_cur;
    logic [TW:0]     sub_full;
    logic [TW-1:0]   tm_sat;
    logic [CW-1:0]   lim;
    logic            last_slot;
    logic            s_accept;
    logic            cfg_we;
    logic [CW-1:0]   live_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;

    // Slot under the sequencer and the shared saturating subtractor.
    assign slot      = cnt_reg[tspl_pkg::IDX_W-1:0];
    assign ph_cur    = phase_reg[slot];
    assign sub_full  = {1'b0, timer_reg[slot]} - {1'b0, dt_reg};
    assign tm_sat    = sub_full[TW] ? '0 : sub_full[TW-1:0];
    assign last_slot = (cnt_reg == CW'(tspl_pkg::SLOTS - 1));
    assign lim = (32'(cfg_siu_reg) > tspl_pkg::SLOTS) ? CW'(tspl_pkg::SLOTS)
                                                      : CW'(cfg_siu_reg);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_siu_reg   <= tspl_pkg::SIU_RESET;
            cfg_limit_reg <= tspl_pkg::LIMIT_RESET;
            cfg_fade_reg  <= tspl_pkg::FADE_RESET;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                tspl_pkg::REG_SLOTS_IN_USE: cfg_siu_reg   <= pwdata[tspl_pkg::SIU_W-1:0];
                tspl_pkg::REG_LINGER_LIMIT: cfg_limit_reg <= pwdata[tspl_pkg::LIMIT_W-1:0];
                tspl_pkg::REG_FADE_MS:      cfg_fade_reg  <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    // Configuration reads.
    always_comb begin
        unique case (paddr[3:2])
            tspl_pkg::REG_SLOTS_IN_USE: prdata = 32'(cfg_siu_reg);
            tspl_pkg::REG_LINGER_LIMIT: prdata = 32'(cfg_limit_reg);
            tspl_pkg::REG_FADE_MS:      prdata = 32'(cfg_fade_reg);
            default:                    prdata = '0;
        endcase
    end

    // Sequencer: one slot per cycle in every pass.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        live_next     = live_reg;
        excess_next   = excess_reg;
        evict_next    = evict_reg;
        res_idx_next  = res_idx_reg;
        res_ok_next   = res_ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ph_we    = 1'b0;
        ph_wdata = tspl_pkg::PH_FREE;
        tm_we    = 1'b0;
        tm_wdata = tm_sat;
        lg_we    = 1'b0;
        lg_wdata = !fot_reg;
        live_inc = live_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cnt_next     = '0;
                    live_next    = '0;
                    evict_next   = '0;
                    excess_next  = '0;
                    res_idx_next = '0;
                    res_ok_next  = 1'b0;
                    unique case (s_tuser)
                        tspl_pkg::OP_SPAWN: state_next = (lim != '0) ? ST_SPAWN : ST_DONE;
                        tspl_pkg::OP_TICK:  state_next = ST_TICK;
                        tspl_pkg::OP_CLEAR: state_next = ST_CLEAR;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SPAWN: begin
                // Probe the lowest untested slot below the spawn limit.
                if (ph_cur == tspl_pkg::PH_FREE) begin
                    ph_we        = 1'b1;
                    ph_wdata     = tspl_pkg::PH_ACTIVE;
                    tm_we        = 1'b1;
                    tm_wdata     = life_reg;
                    lg_we        = 1'b1;
                    res_ok_next  = 1'b1;
                    res_idx_next = tspl_pkg::OUT_IDX_W'(slot);
                    state_next   = ST_DONE;
                end else if (cnt_reg + CW'(1) >= lim) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_TICK: begin
                // Count live slots and age every timed slot.
                if (ph_cur != tspl_pkg::PH_FREE) begin
                    if (ph_cur != tspl_pkg::PH_FADE) begin
                        live_inc = live_reg + CW'(1);
                    end
                    if (ph_cur != tspl_pkg::PH_LINGER) begin
                        tm_we = 1'b1;
                        if (tm_sat == '0) begin
                            ph_we = 1'b1;
                            if (ph_cur == tspl_pkg::PH_FADE) begin
                                ph_wdata = tspl_pkg::PH_FREE;
                            end else if (lingers_reg[slot]) begin
                                ph_wdata = tspl_pkg::PH_LINGER;
                            end else begin
                                ph_wdata = tspl_pkg::PH_FADE;
                                tm_wdata = cfg_fade_reg;
                            end
                        end
                    end
                end
                live_next = live_inc;
                if (last_slot) begin
                    cnt_next = '0;
                    if (32'(live_inc) >= 32'(cfg_limit_reg)) begin
                        excess_next = EW'(32'(live_inc) + 32'd1 - 32'(cfg_limit_reg));
                        state_next  = ST_EVICT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_EVICT: begin
                // Force the first excess lingering slots into fading.
                if (ph_cur == tspl_pkg::PH_LINGER) begin
                    ph_we       = 1'b1;
                    ph_wdata    = tspl_pkg::PH_FADE;
                    tm_we       = 1'b1;
                    tm_wdata    = cfg_fade_reg;
                    excess_next = excess_reg - EW'(1);
                    evict_next  = evict_reg + CW'(1);
                end
                if (last_slot || (excess_next == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_CLEAR: begin
                ph_we    = 1'b1;
                ph_wdata = tspl_pkg::PH_FREE;
                if (last_slot) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     tspl_pkg::OUT_CNT_W'(evict_reg),
                                     tspl_pkg::OUT_CNT_W'(live_reg),
                                     res_ok_reg,
                                     res_idx_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            live_reg     <= '0;
            excess_reg   <= '0;
            evict_reg    <= '0;
            res_idx_reg  <= '0;
            res_ok_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            live_reg     <= live_next;
            excess_reg   <= excess_next;
            evict_reg    <= evict_next;
            res_idx_reg  <= res_idx_next;
            res_ok_reg   <= res_ok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Output payload and captured transaction fields.
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (s_accept) begin
            op_reg   <= s_tuser;
            life_reg <= s_tdata[15:0];
            fot_reg  <= s_tdata[16];
            dt_reg   <= s_tdata[32:17];
        end
    end

    // Slot phases reset to free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < tspl_pkg::SLOTS; i++) begin
                phase_reg[i] <= tspl_pkg::PH_FREE;
            end
        end else if (ph_we) begin
            phase_reg[slot] <= ph_wdata;
        end
    end

    // Timers and linger flags are only read for slots that have been spawned.
    always_ff @(posedge aclk) begin
        if (tm_we) begin
            timer_reg[slot] <= tm_wdata;
        end
        if (lg_we) begin
            lingers_reg[slot] <= lg_wdata;
        end
    end

    // A spawn result never carries tick counts.
    a_spawn_no_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tdata_reg[4]) |-> (m_tdata_reg[14:5] == '0))
        else $error("spawn result carries tick counts");

    // Evictions never exceed the live count plus one.
    a_evict_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tdata_reg[14:10] <= m_tdata_reg[9:5] + 5'd1))
        else $error("evicted count exceeds live count plus one");

    // Spawn success is flagged only when the opcode spawns.
    a_ok_only_spawn: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_ok_reg) |-> (op_reg == tspl_pkg::OP_SPAWN))
        else $error("spawn success flagged for a non-spawn operation");

    // The spawn probe stays below the spawn limit.
    a_spawn_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPAWN) |-> (cnt_reg < lim))
        else $error("spawn probe beyond slots in use");

    // An eviction pass only runs while evictions remain owed.
    a_evict_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVICT) |-> (excess_reg != '0))
        else $error("eviction pass with nothing owed");

endmodule
